// ----- sv/bb_pkg.sv -----
// ---------------------------------------------------------------------------
// bb_pkg
// Types, constants and helpers shared by the 3x3 box blur blocks.
// ---------------------------------------------------------------------------
`default_nettype none

package bb_pkg;

  localparam int CFG_W    = 11;       // frame size register width
  localparam int CFG_IX_W = 1;        // register index width
  localparam int ROW_W    = CFG_W + 1; // input row runs up to height + 1
  localparam int CH_W     = 8;
  localparam int PIX_W    = 3 * CH_W;
  localparam int SUM_W    = 12;       // 9 * 255 fits
  localparam int NUM_W    = SUM_W + 1; // 2 * sum + count
  localparam int CNT_W    = 4;        // 1, 2, 3, 4, 6 or 9 taps
  localparam int RECIP_W  = 24;
  localparam int RECIP_SH = 24;
  localparam int Q_DEPTH  = 4;        // command queue depth

  localparam logic [CFG_W-1:0]    DEFAULT_SIZE     = 11'd1024;
  localparam logic [CFG_IX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  // Which neighbor rows / columns lie inside the frame.
  typedef struct packed {
    logic row_up;
    logic row_dn;
    logic col_lf;
    logic col_rt;
  } mask_t;

  // One classified item handed from front to back.
  typedef struct packed {
    logic [PIX_W-1:0] pix;  // {red, green, blue}; zero for drain
    logic             emit; // item completes a result
    mask_t            mask;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            last;
  } res_t;

  // ceil(2^24 / (2 * count)); exact floor division for numerators below 2^13
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
    logic [RECIP_W-1:0] m;
    unique case (cnt)
      4'd1:    m = 24'd8388608;
      4'd2:    m = 24'd4194304;
      4'd3:    m = 24'd2796203;
      4'd4:    m = 24'd2097152;
      4'd6:    m = 24'd1398102;
      4'd9:    m = 24'd932068;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- sv/bb_cmd_fifo.sv -----
// ---------------------------------------------------------------------------
// bb_cmd_fifo
// Short command queue between the classifying front and the filter back.
// ---------------------------------------------------------------------------
`default_nettype none

module bb_cmd_fifo
  import bb_pkg::*;
#(
  parameter int DW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire logic [DW-1:0] din,
  output logic               full,
  input  wire logic          pop,
  output logic [DW-1:0]      dout,
  output logic               empty
);

  localparam int AW = $clog2(Q_DEPTH);

  logic [DW-1:0] mem_r [Q_DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (AW+1)'(Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) wp_nxt = wp_r + AW'(1);
    if (pop)  rp_nxt = rp_r + AW'(1);
    priority if (push && !pop) cnt_nxt = cnt_r + (AW+1)'(1);
    else if (pop && !push)     cnt_nxt = cnt_r - (AW+1)'(1);
    else                       cnt_nxt = cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= din;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop)) else $error("command queue overflow");

endmodule

`default_nettype wire

// ----- sv/bb_front.sv -----
// ---------------------------------------------------------------------------
// bb_front
// Frame bookkeeping: accepts items, drops stray drains, tags each kept item
// with its column, border mask and end-of-frame flag.
// ---------------------------------------------------------------------------
`default_nettype none

module bb_front
  import bb_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int COL_W      = 10
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [CFG_IX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_wdata,
  input  wire logic                in_push,
  input  wire logic                in_command,
  input  wire logic [CH_W-1:0]     in_red,
  input  wire logic [CH_W-1:0]     in_green,
  input  wire logic [CH_W-1:0]     in_blue,
  input  wire logic                q_full,
  output logic                     q_push,
  output logic [COL_W-1:0]         q_col,
  output cmd_t                     q_cmd
);

  function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] raw,
                                                  input int maxv);
    logic [CFG_W-1:0] v;
    v = raw;
    if (raw == '0) v = CFG_W'(1);
    else if (int'(raw) > maxv) v = CFG_W'(maxv);
    return v;
  endfunction

  logic [CFG_W-1:0] w_r, h_r;
  logic [CFG_W-1:0] col_r, col_nxt, kc_r, kc_nxt, kr_r, kr_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             pix_phase, ignore, take, emit, last;
  logic             col_wrap, kc_wrap;

  always_comb begin
    pix_phase = row_r < {1'b0, h_r};
    ignore    = pix_phase && in_command;   // drain while pixels still due
    take      = in_push && !q_full && !ignore;
    col_wrap  = (col_r == w_r - CFG_W'(1));
    kc_wrap   = (kc_r == w_r - CFG_W'(1));
    // a result is due once width+1 items have gone by
    emit      = (row_r >= ROW_W'(2)) || ((row_r == ROW_W'(1)) && (col_r != '0));
    last      = emit && kc_wrap && (kr_r == h_r - CFG_W'(1));

    col_nxt = col_r;
    row_nxt = row_r;
    kc_nxt  = kc_r;
    kr_nxt  = kr_r;
    if (take) begin
      if (last) begin
        col_nxt = '0;
        row_nxt = '0;
        kc_nxt  = '0;
        kr_nxt  = '0;
      end else begin
        if (col_wrap) begin
          col_nxt = '0;
          row_nxt = row_r + ROW_W'(1);
        end else begin
          col_nxt = col_r + CFG_W'(1);
        end
        if (emit) begin
          if (kc_wrap) begin
            kc_nxt = '0;
            kr_nxt = kr_r + CFG_W'(1);
          end else begin
            kc_nxt = kc_r + CFG_W'(1);
          end
        end
      end
    end
  end

  assign q_push          = take;
  assign q_col           = COL_W'(col_r);
  assign q_cmd.pix       = pix_phase ? {in_red, in_green, in_blue} : '0;
  assign q_cmd.emit      = emit;
  assign q_cmd.mask.row_up = (kr_r != '0);
  assign q_cmd.mask.row_dn = (kr_r != h_r - CFG_W'(1));
  assign q_cmd.mask.col_lf = (kc_r != '0);
  assign q_cmd.mask.col_rt = !kc_wrap;
  assign q_cmd.last      = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r   <= clamp_size(DEFAULT_SIZE, MAX_WIDTH);
      h_r   <= clamp_size(DEFAULT_SIZE, MAX_HEIGHT);
      col_r <= '0;
      row_r <= '0;
      kc_r  <= '0;
      kr_r  <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_FRAME_WIDTH) w_r <= clamp_size(cfg_wdata, MAX_WIDTH);
      if (cfg_index == CFG_FRAME_HEIGHT) h_r <= clamp_size(cfg_wdata, MAX_HEIGHT);
      col_r <= '0;
      row_r <= '0;
      kc_r  <= '0;
      kr_r  <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      kc_r  <= kc_nxt;
      kr_r  <= kr_nxt;
    end
  end

  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    (col_r < w_r) && (kc_r < w_r)) else $error("column counter past frame width");
  a_kr_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    kr_r < h_r) else $error("result row past frame height");

endmodule

`default_nettype wire

// ----- sv/bb_back.sv -----
// ---------------------------------------------------------------------------
// bb_back
// Line buffers, 3x3 window, masked sums and rounded division, result queue.
// ---------------------------------------------------------------------------
`default_nettype none

module bb_back
  import bb_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int COL_W     = 10
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_empty,
  input  wire logic [COL_W-1:0] q_col,
  input  wire cmd_t             q_cmd,
  output logic                  q_pop,
  input  wire logic             pop,
  output logic                  empty,
  output res_t                  res
);

  localparam int OUT_DEPTH = 2;
  localparam int PROD_W    = NUM_W + RECIP_W;

  // line buffers: {two rows back, one row back} per column
  logic [2*PIX_W-1:0] row_mem_r [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_r, rd_eff, byp_d_r;
  logic               byp_v_r;

  logic               b1_v_r, b2_v_r, b3_v_r;
  cmd_t               b1_cmd_r, b2_cmd_r;
  logic [COL_W-1:0]   b1_col_r;
  logic [PIX_W-1:0]   win_r [9];

  logic [NUM_W-1:0]   num_r [3];
  logic [RECIP_W-1:0] recip_r;
  logic               b3_last_r;

  res_t               ent_r [OUT_DEPTH];
  logic               wp_r, rp_r;
  logic [1:0]         ocnt_r, ocnt_nxt;
  logic               adv, opop, opush;

  logic [1:0]         rows, cols;
  logic [CNT_W-1:0]   cnt;
  logic [SUM_W-1:0]   sum [3];
  logic [NUM_W-1:0]   num [3];
  logic [2:0]         rok, cok;
  logic [PROD_W-1:0]  prod [3];
  res_t               res_new;

  assign opop   = pop && (ocnt_r != '0);
  assign adv    = (ocnt_r != 2'(OUT_DEPTH)) || opop;
  assign q_pop  = adv && !q_empty;
  assign opush  = adv && b3_v_r;
  assign empty  = (ocnt_r == '0);
  assign res    = ent_r[rp_r];
  assign rd_eff = byp_v_r ? byp_d_r : rd_r;

  // window taps: index row*3 + col, row 0 oldest line, col 2 newest column
  always_comb begin
    rok = {b2_cmd_r.mask.row_dn, 1'b1, b2_cmd_r.mask.row_up};
    cok = {b2_cmd_r.mask.col_rt, 1'b1, b2_cmd_r.mask.col_lf};
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if (rok[i] && cok[j]) sum[ch] = sum[ch] + SUM_W'(win_r[i*3+j][ch*CH_W +: CH_W]);
        end
      end
    end
    rows = 2'd1 + 2'(b2_cmd_r.mask.row_up) + 2'(b2_cmd_r.mask.row_dn);
    cols = 2'd1 + 2'(b2_cmd_r.mask.col_lf) + 2'(b2_cmd_r.mask.col_rt);
    cnt  = CNT_W'(rows) * CNT_W'(cols);
    for (int ch = 0; ch < 3; ch++) begin
      num[ch] = {sum[ch], 1'b0} + NUM_W'(cnt);
    end
  end

  // (2*sum + cnt) / (2*cnt) by reciprocal multiply; exact for this range
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = PROD_W'(num_r[ch]) * PROD_W'(recip_r);
    end
    res_new.red   = prod[2][RECIP_SH +: CH_W];
    res_new.green = prod[1][RECIP_SH +: CH_W];
    res_new.blue  = prod[0][RECIP_SH +: CH_W];
    res_new.last  = b3_last_r;
  end

  always_comb begin
    ocnt_nxt = ocnt_r;
    priority if (opush && !opop) ocnt_nxt = ocnt_r + 2'd1;
    else if (opop && !opush)     ocnt_nxt = ocnt_r - 2'd1;
    else                         ocnt_nxt = ocnt_r;
  end

  // line buffer port: one write and one registered read per advance
  always_ff @(posedge clk) begin
    if (adv && b1_v_r) row_mem_r[b1_col_r] <= {rd_eff[PIX_W-1:0], b1_cmd_r.pix};
    if (q_pop) rd_r <= row_mem_r[q_col];
  end

  // control and window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r  <= 1'b0;
      b2_v_r  <= 1'b0;
      b3_v_r  <= 1'b0;
      byp_v_r <= 1'b0;
      wp_r    <= 1'b0;
      rp_r    <= 1'b0;
      ocnt_r  <= '0;
      for (int i = 0; i < 9; i++) win_r[i] <= '0;
    end else begin
      ocnt_r <= ocnt_nxt;
      if (opush) wp_r <= !wp_r;
      if (opop)  rp_r <= !rp_r;
      if (adv) begin
        b1_v_r  <= !q_empty;
        // same column read while the previous item writes it back
        byp_v_r <= !q_empty && b1_v_r && (b1_col_r == q_col);
        b2_v_r  <= b1_v_r;
        b3_v_r  <= b2_v_r && b2_cmd_r.emit;
        if (b1_v_r) begin
          for (int i = 0; i < 3; i++) begin
            win_r[i*3]   <= win_r[i*3+1];
            win_r[i*3+1] <= win_r[i*3+2];
          end
          win_r[2] <= rd_eff[2*PIX_W-1:PIX_W];
          win_r[5] <= rd_eff[PIX_W-1:0];
          win_r[8] <= b1_cmd_r.pix;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      b1_cmd_r  <= q_cmd;
      b1_col_r  <= q_col;
      byp_d_r   <= {rd_eff[PIX_W-1:0], b1_cmd_r.pix};
      b2_cmd_r  <= b1_cmd_r;
      num_r     <= num;
      recip_r   <= recip(cnt);
      b3_last_r <= b2_cmd_r.last;
    end
    if (opush) ent_r[wp_r] <= res_new;
  end

  a_byp_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    byp_v_r |-> b1_v_r) else $error("bypass without a loaded item");
  a_ocnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r <= 2'(OUT_DEPTH)) else $error("result queue count out of range");

endmodule

`default_nettype wire

// ----- sv/box_blur_3x3_rgb.sv -----
// ---------------------------------------------------------------------------
// box_blur_3x3_rgb
// Streaming 3x3 box blur over RGB frames, edge normalized, round half up.
// ---------------------------------------------------------------------------
// Pixels enter in raster order and each output is the mean of the in-frame
// part of its 3x3 neighborhood (4 taps at corners, 6 on edges, 9 inside),
// per channel, rounded as (2*sum+count)/(2*count). Result k leaves on input
// transfer k+width+1, so after the height*width pixels send width+1 drain
// transfers (command=1) to flush the frame; last_of_frame marks the final
// result and the next transfer starts a new frame. A drain while pixels are
// still due is dropped; a pixel after the frame's pixels counts as a drain.
// Sustained rate is one transfer per clock on both sides: the input side
// stalls only when the four-entry command queue fills, which happens when
// the result side holds pop low. A transfer that completes a result passes
// the command queue, the line buffer read, the window, the sum and the
// multiply stage and the result queue before that result shows on the
// outputs. Width and height
// writes (0 reads as 1, above MAX_WIDTH/MAX_HEIGHT reads as that maximum)
// restart the frame and must be made while the block is idle. The two line
// buffers share one MAX_WIDTH x 48 memory and are not cleared; taps that
// would read stale entries are always outside the frame and masked.
// ---------------------------------------------------------------------------
`default_nettype none

module box_blur_3x3_rgb
  import bb_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // configuration
  input  wire logic                cfg_we,
  input  wire logic [CFG_IX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_wdata,
  // input transfers
  input  wire logic                push,
  output logic                     full,
  input  wire logic                in_command,
  input  wire logic [CH_W-1:0]     in_red_in,
  input  wire logic [CH_W-1:0]     in_green_in,
  input  wire logic [CH_W-1:0]     in_blue_in,
  // result transfers
  output logic                     empty,
  input  wire logic                pop,
  output logic [CH_W-1:0]          out_red_out,
  output logic [CH_W-1:0]          out_green_out,
  output logic [CH_W-1:0]          out_blue_out,
  output logic                     out_last_of_frame
);

  // column index into the line buffers
  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int QW    = COL_W + $bits(cmd_t);

  logic             fq_push, q_full, q_empty, q_pop;
  logic [COL_W-1:0] fq_col, bq_col;
  cmd_t             fq_cmd, bq_cmd;
  logic [QW-1:0]    q_dout;
  res_t             res;

  // front: frame counters, classification
  bb_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .COL_W      (COL_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_push    (push),
    .in_command (in_command),
    .in_red     (in_red_in),
    .in_green   (in_green_in),
    .in_blue    (in_blue_in),
    .q_full     (q_full),
    .q_push     (fq_push),
    .q_col      (fq_col),
    .q_cmd      (fq_cmd)
  );

  // decoupling queue
  bb_cmd_fifo #(
    .DW (QW)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fq_push),
    .din   ({fq_col, fq_cmd}),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  assign bq_col = q_dout[QW-1 -: COL_W];
  assign bq_cmd = cmd_t'(q_dout[$bits(cmd_t)-1:0]);

  // back: line buffers, window, averaging, result queue
  bb_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .COL_W     (COL_W)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_col   (bq_col),
    .q_cmd   (bq_cmd),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .res     (res)
  );

  assign full              = q_full;
  assign out_red_out       = res.red;
  assign out_green_out     = res.green;
  assign out_blue_out      = res.blue;
  assign out_last_of_frame = res.last;

endmodule

`default_nettype wire
